>>> hdl/ccdv_pkg.sv
// ccdv_pkg: shared types, constants and helper functions for the CPF
// check digit validator. No dependencies.
package ccdv_pkg;

  // Field widths
  localparam int VAL_W  = 37;          // binary CPF number
  localparam int DIFF_W = VAL_W + 1;   // trial subtract with borrow bit
  localparam int SUM_W  = 10;          // weighted sums stay below 600
  localparam int DIG_W  = 4;           // one decimal digit
  localparam int QUO_W  = 6;           // sum / 11 stays below 64

  // Scheme constants
  localparam logic [VAL_W-1:0] CPF_MAX = 37'd99999999999;
  localparam int NUM_CELLS  = 10;      // digit positions 10 down to 1
  localparam int TOP_POS    = 10;
  localparam int MOD_BASE   = 11;
  localparam int MAX_DIGIT  = 9;
  localparam int PREV_WEIGHT = 2;      // weight of the first check digit in the second sum

  // Reciprocal of 11 for the remainder: q = (s * RECIP_11) >> RECIP_SHIFT
  localparam int RECIP_11    = 5958;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 13;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // Payload handed from cell to cell
  typedef struct packed {
    logic [VAL_W-1:0] value;   // original number, kept for the result
    logic [VAL_W-1:0] rem;     // digits not yet taken apart
    logic [SUM_W-1:0] sum1;    // weights 2..10
    logic [SUM_W-1:0] sum2;    // weights 3..11 plus twice the first check digit
    logic [DIG_W-1:0] digit;   // digit taken by the last cell
    logic             bad;     // number out of range
  } lane_t;

  // Power of ten for a digit position
  function automatic logic [VAL_W-1:0] pow10(input int pos);
    logic [VAL_W-1:0] p;
    p = VAL_W'(1);
    for (int k = 0; k < pos; k++) begin
      p = p * VAL_W'(10);
    end
    return p;
  endfunction

  // Weight of a position in the first sum
  function automatic int weight_first(input int pos);
    return (pos >= 2) ? pos : 0;
  endfunction

  // Weight of a position in the second sum
  function automatic int weight_second(input int pos);
    return (pos >= 2) ? pos + 1 : ((pos == 1) ? PREV_WEIGHT : 0);
  endfunction

  // Check digit expected for a remainder mod 11
  function automatic logic [DIG_W-1:0] expected_digit(input logic [DIG_W-1:0] r);
    return (r < DIG_W'(2)) ? '0 : DIG_W'(MOD_BASE) - r;
  endfunction

endpackage

>>> hdl/cpf_check_digit_validator_unit.sv
// Path: an input transfer reaches its result through 10 digit cells and 2 check stages.
// Throughput: one item per cycle when no result is held; every cell and check stage holds one.
// Ready passes back through the whole row in the same cycle; a held result stalls the input
// only once every cell is full, and empty cells still accept while the result waits.
// Reset: synchronous active-high rst empties the chain and the result register.
// Uses ccdv_pkg, ccdv_digit_cell and ccdv_check.
module cpf_check_digit_validator_unit
  import ccdv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [VAL_W-1:0] cpf_value,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             is_valid,
  output logic [VAL_W-1:0] accepted_value
);

  lane_t entry_lane;
  lane_t lanes  [0:NUM_CELLS];
  logic  valids [0:NUM_CELLS];
  logic  readys [0:NUM_CELLS];

  // Enter the chain with the full number and empty sums
  always_comb begin
    entry_lane       = '0;
    entry_lane.value = cpf_value;
    entry_lane.rem   = cpf_value;
    entry_lane.bad   = cpf_value > CPF_MAX;
  end

  assign lanes[0]   = entry_lane;
  assign valids[0]  = item_valid;
  assign item_stall = !readys[0];

  // Row of digit cells, most significant digit first
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    ccdv_digit_cell #(
      .POS(TOP_POS - i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(valids[i]),
      .up_ready(readys[i]),
      .up_lane (lanes[i]),
      .dn_valid(valids[i+1]),
      .dn_ready(readys[i+1]),
      .dn_lane (lanes[i+1])
    );
  end

  // Mod-11 check and result register
  ccdv_check u_check (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (valids[NUM_CELLS]),
    .up_ready      (readys[NUM_CELLS]),
    .up_lane       (lanes[NUM_CELLS]),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .is_valid      (is_valid),
    .accepted_value(accepted_value)
  );

  // An invalid number never passes its value on
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_valid |-> accepted_value == '0)
    else $error("invalid result carries a nonzero value");

  // A valid number is always in range
  assert property (@(posedge clk) disable iff (rst)
    result_valid && is_valid |-> accepted_value <= CPF_MAX)
    else $error("valid result out of range");

  // The input stalls only when the whole chain is full and the result is held
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled with room in the chain");

  // Reset empties the result register
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

>>> hdl/ccdv_digit_cell.sv
// ccdv_digit_cell: one cell of the digit chain; takes one decimal digit
// off the remaining value and adds it into both weighted sums. Uses ccdv_pkg.
module ccdv_digit_cell
  import ccdv_pkg::*;
#(
  parameter int POS = TOP_POS
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  lane_t up_lane,
  output logic  dn_valid,
  input  logic  dn_ready,
  output lane_t dn_lane
);

  localparam logic [VAL_W-1:0] POWER = pow10(POS);
  localparam int W1 = weight_first(POS);
  localparam int W2 = weight_second(POS);

  logic              vld;
  lane_t             lane;
  lane_t             lane_next;
  logic [DIFF_W-1:0] diff [1:MAX_DIGIT];
  logic [DIG_W-1:0]  digit;
  logic [VAL_W-1:0]  rem_next;

  // Trial subtract every multiple of the power in parallel
  always_comb begin
    for (int d = 1; d <= MAX_DIGIT; d++) begin
      diff[d] = {1'b0, up_lane.rem} - DIFF_W'(d) * {1'b0, POWER};
    end
  end

  // Pick the largest multiple that fits
  always_comb begin
    digit    = '0;
    rem_next = up_lane.rem;
    for (int d = 1; d <= MAX_DIGIT; d++) begin
      if (!diff[d][DIFF_W-1]) begin
        digit    = DIG_W'(d);
        rem_next = diff[d][VAL_W-1:0];
      end
    end
  end

  // Accumulate the weighted sums
  always_comb begin
    lane_next       = up_lane;
    lane_next.rem   = rem_next;
    lane_next.digit = digit;
    lane_next.sum1  = up_lane.sum1 + SUM_W'(digit) * SUM_W'(W1);
    lane_next.sum2  = up_lane.sum2 + SUM_W'(digit) * SUM_W'(W2);
  end

  // Advance when empty or when the next cell takes its transfer
  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      lane <= lane_next;
    end
  end

  assign dn_valid = vld;
  assign dn_lane  = lane;

endmodule

>>> hdl/ccdv_check.sv
// ccdv_check: reduces both sums mod 11 and compares against the check
// digits, two register stages, the second being the result register. Uses ccdv_pkg.
module ccdv_check
  import ccdv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  lane_t            up_lane,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             is_valid,
  output logic [VAL_W-1:0] accepted_value
);

  // Stage A registers
  logic             a_vld;
  logic [QUO_W-1:0] a_q1;
  logic [QUO_W-1:0] a_q2;
  logic [SUM_W-1:0] a_sum1;
  logic [SUM_W-1:0] a_sum2;
  logic [DIG_W-1:0] a_prev;
  logic [DIG_W-1:0] a_last;
  logic             a_bad;
  logic [VAL_W-1:0] a_value;
  logic             a_ready;

  // Stage B (result) registers
  logic             b_vld;
  logic             b_ok;
  logic [VAL_W-1:0] b_value;
  logic             b_ready;

  logic [PROD_W-1:0] prod1;
  logic [PROD_W-1:0] prod2;
  logic [DIG_W-1:0]  r1;
  logic [DIG_W-1:0]  r2;
  logic [SUM_W-1:0]  full_r1;
  logic [SUM_W-1:0]  full_r2;
  logic              ok_next;

  // Quotient by 11 through the reciprocal
  assign prod1 = PROD_W'(up_lane.sum1) * PROD_W'(RECIP_11);
  assign prod2 = PROD_W'(up_lane.sum2) * PROD_W'(RECIP_11);

  assign b_ready  = !b_vld || !result_stall;
  assign a_ready  = !a_vld || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_ready) begin
      a_vld <= up_valid;
    end
  end

  // Hold the quotients, the sums, the two check digits, the range flag and the number
  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_q1    <= prod1[RECIP_SHIFT +: QUO_W];
      a_q2    <= prod2[RECIP_SHIFT +: QUO_W];
      a_sum1  <= up_lane.sum1;
      a_sum2  <= up_lane.sum2;
      a_prev  <= up_lane.digit;
      a_last  <= up_lane.rem[DIG_W-1:0];
      a_bad   <= up_lane.bad || (up_lane.rem[VAL_W-1:DIG_W] != '0);
      a_value <= up_lane.value;
    end
  end

  // Remainders and comparison
  assign full_r1 = a_sum1 - SUM_W'(a_q1) * SUM_W'(MOD_BASE);
  assign full_r2 = a_sum2 - SUM_W'(a_q2) * SUM_W'(MOD_BASE);
  assign r1      = full_r1[DIG_W-1:0];
  assign r2      = full_r2[DIG_W-1:0];
  assign ok_next = !a_bad && (a_prev == expected_digit(r1)) && (a_last == expected_digit(r2));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (b_ready) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_vld) begin
      b_ok    <= ok_next;
      b_value <= ok_next ? a_value : '0;
    end
  end

  assign result_valid   = b_vld;
  assign is_valid       = b_ok;
  assign accepted_value = b_value;

endmodule

>>> test/cpf_check_digit_validator_unit_tb.sv
// Self-checking testbench for cpf_check_digit_validator_unit: drives CPF numbers
// under random idling and back-pressure and checks each result against its own model.
// Depends on ccdv_pkg and the cpf_check_digit_validator_unit RTL.
module cpf_check_digit_validator_unit_tb
  import ccdv_pkg::*;
;

  localparam longint unsigned CPF_TOP = 64'd99999999999;
  localparam longint unsigned BASE_TOP = 64'd999999999;
  localparam int MOD = 11;
  localparam int IDLE_PCT = 33;
  localparam int HOLD_CYCLES = 90;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic             is_valid;
    logic [VAL_W-1:0] accepted_value;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  logic [VAL_W-1:0] cpf_value = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic             is_valid;
  logic [VAL_W-1:0] accepted_value;

  logic [VAL_W-1:0] pending_q[$];
  verdict_t         verdict_q[$];
  int               queued_cnt = 0;
  int               sent_cnt = 0;
  int               mismatches = 0;
  int               idle_cycles = 0;
  int               hold_left = 0;
  bit               held = 1'b0;
  bit               quiet = 1'b0;

  cpf_check_digit_validator_unit dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .cpf_value      (cpf_value),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .is_valid       (is_valid),
    .accepted_value (accepted_value)
  );

  always #1 clk = ~clk;

  // Weighted sum of nine base digits, weights rising from the least significant one
  function automatic int digit_sum(input longint unsigned base, input int first_w);
    int s;
    longint unsigned rest;
    s = 0;
    rest = base;
    for (int w = first_w; w < first_w + 9; w++) begin
      s += int'(rest % 10) * w;
      rest /= 10;
    end
    return s;
  endfunction

  // Check digit demanded by a weighted sum
  function automatic int check_of(input int s);
    return (s % MOD < 2) ? 0 : MOD - s % MOD;
  endfunction

  // Append both check digits to a nine-digit base
  function automatic longint unsigned make_cpf(input longint unsigned base);
    int d1;
    int d2;
    d1 = check_of(digit_sum(base, 2));
    d2 = check_of(digit_sum(base, 3) + 2 * d1);
    return base * 100 + d1 * 10 + d2;
  endfunction

  // Replace the decimal digit at position pos (0 = last check digit)
  function automatic longint unsigned with_digit(input longint unsigned num, input int pos,
                                                 input int dig);
    longint unsigned pw;
    pw = 1;
    repeat (pos) pw *= 10;
    return num - ((num / pw) % 10) * pw + longint'(dig) * pw;
  endfunction

  // Bump one digit to a different value
  function automatic longint unsigned spoil_digit(input longint unsigned num, input int pos);
    longint unsigned pw;
    int old;
    pw = 1;
    repeat (pos) pw *= 10;
    old = int'((num / pw) % 10);
    return with_digit(num, pos, (old + $urandom_range(1, 9)) % 10);
  endfunction

  // Expected result for one number
  function automatic verdict_t cpf_verdict(input logic [VAL_W-1:0] num);
    verdict_t v;
    longint unsigned n;
    int d1;
    int d2;
    v = '0;
    n = longint'(num);
    if (n > CPF_TOP) return v;
    d1 = int'((n / 10) % 10);
    d2 = int'(n % 10);
    if (d1 == check_of(digit_sum(n / 100, 2)) &&
        d2 == check_of(digit_sum(n / 100, 3) + 2 * d1)) begin
      v.is_valid = 1'b1;
      v.accepted_value = num;
    end
    return v;
  endfunction

  // Mostly well-formed numbers, the rest spoiled, short, near the top of the range, or raw bit patterns
  function automatic logic [VAL_W-1:0] random_cpf();
    int pick;
    longint unsigned raw;
    longint unsigned good;
    pick = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    good = make_cpf($urandom_range(0, int'(BASE_TOP)));
    if (pick < 55) return VAL_W'(good);
    if (pick < 70) return VAL_W'(spoil_digit(good, $urandom_range(0, 1)));
    if (pick < 80) return VAL_W'(spoil_digit(good, $urandom_range(2, 10)));
    if (pick < 87) return VAL_W'(raw % (CPF_TOP + 1));
    if (pick < 92) return VAL_W'(make_cpf($urandom_range(0, 999)));
    if (pick < 95) return VAL_W'(CPF_TOP - $urandom_range(0, 300));
    return VAL_W'(raw);
  endfunction

  task automatic queue_item(input longint unsigned num);
    pending_q.push_back(VAL_W'(num));
    queued_cnt++;
  endtask

  task automatic queue_random(input int n);
    repeat (n) begin
      pending_q.push_back(random_cpf());
      queued_cnt++;
    end
  endtask

  // Hold until every queued number went in and every result came back
  task automatic drain();
    while (sent_cnt != queued_cnt || verdict_q.size() != 0) @(negedge clk);
  endtask

  // Driver: record each transfer, then offer the next number or idle
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        verdict_q.push_back(cpf_verdict(cpf_value));
        sent_cnt++;
      end
      if (!item_valid || !item_stall) begin
        if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          item_valid <= 1'b1;
          cpf_value <= pending_q.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold when the quiet phase opens, random stalls otherwise
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (quiet && !held) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (quiet) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && result_valid && !result_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result is_valid=%0b accepted_value=%0d",
                 $time, is_valid, accepted_value);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (is_valid !== want.is_valid) begin
          $display("%0t: is_valid expected %0b actual %0b", $time, want.is_valid, is_valid);
          mismatches++;
        end
        if (accepted_value !== want.accepted_value) begin
          $display("%0t: accepted_value expected %0d actual %0d",
                   $time, want.accepted_value, accepted_value);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("cpf_check_digit_validator_unit_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    longint unsigned base;
    longint unsigned num;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: range edges, bit patterns, known numbers, small remainders, bad digits
    queue_item(0);
    queue_item(1);
    queue_item(191);
    queue_item(CPF_TOP);
    queue_item(CPF_TOP - 1);
    queue_item(CPF_TOP + 1);
    queue_item(64'd100000000000);
    queue_item(64'h1F_FFFF_FFFF);
    queue_item(64'h10_0000_0000);
    queue_item(64'h0A_AAAA_AAAA);
    queue_item(64'h15_5555_5555);
    queue_item(make_cpf(529982247));
    queue_item(make_cpf(111444777));
    queue_item(make_cpf(12345));
    queue_item(spoil_digit(make_cpf(529982247), 1));
    queue_item(spoil_digit(make_cpf(529982247), 0));
    queue_item(spoil_digit(make_cpf(111444777), 6));
    do begin
      base = $urandom_range(0, int'(BASE_TOP));
      num = make_cpf(base);
    end while ((num / 10) % 10 != 0);
    queue_item(num);
    queue_item(spoil_digit(num, 1));
    do begin
      base = $urandom_range(0, int'(BASE_TOP));
      num = make_cpf(base);
    end while (num % 10 != 0);
    queue_item(num);
    queue_item(spoil_digit(num, 0));
    drain();

    queue_random(300);
    drain();

    // Full rate on both sides after one long receiver hold
    quiet = 1'b1;
    queue_random(200);
    drain();
    quiet = 1'b0;

    queue_random(280);
    drain();
    repeat (30) @(negedge clk);

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("cpf_check_digit_validator_unit_tb OK");
    end else begin
      $display("cpf_check_digit_validator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ccdv_pkg.sv
hdl/ccdv_digit_cell.sv
hdl/ccdv_check.sv
hdl/cpf_check_digit_validator_unit.sv
test/cpf_check_digit_validator_unit_tb.sv
